FILE: rtl/tcp_pkg.sv
// Shared types and constants for the terminal cursor positioner.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package tcp_pkg;

    // Screen size limits; margins and screen edges above them are capped.
    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 256;

    // Depth of the queue between the front end and the back end.
    localparam int FIFO_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TOP_MARGIN    = 3'd0;
    localparam logic [2:0] CFG_BOTTOM_MARGIN = 3'd1;
    localparam logic [2:0] CFG_LAST_ROW      = 3'd2;
    localparam logic [2:0] CFG_LAST_COL      = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_MODE   = 3'd4;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_LEFT    = 3'd1,
        OP_RIGHT   = 3'd2,
        OP_DOWN    = 3'd3,
        OP_UP      = 3'd4,
        OP_INDEX   = 3'd5,
        OP_REV_IDX = 3'd6,
        OP_CR      = 3'd7
    } op_t;

    // Configuration after capping to the screen size limits.
    typedef struct packed {
        logic [6:0] top;
        logic [6:0] bot;
        logic [6:0] lrow;
        logic [7:0] lcol;
        logic       origin;
    } cfg_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        op_t        op;
        logic [6:0] set_row;
        logic [7:0] set_col;
        logic [7:0] amount;
    } cmd_t;

    function automatic logic [6:0] cap_row(input logic [6:0] v);
        logic [8:0] lim;
        lim = 9'(MAX_ROWS - 1);
        return ({2'b00, v} > lim) ? lim[6:0] : v;
    endfunction

    function automatic logic [7:0] cap_col(input logic [7:0] v);
        logic [9:0] lim;
        lim = 10'(MAX_COLS - 1);
        return ({2'b00, v} > lim) ? lim[7:0] : v;
    endfunction

endpackage

FILE: rtl/tcp_front.sv
// Front end of the cursor positioner: input handshake and command classification.
// Resolves absolute set targets against the margins and screen edges.
// Depends on tcp_pkg.
module tcp_front (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [2:0]     s_operation,
    input  logic [8:0]     s_target_row,
    input  logic [8:0]     s_target_col,
    input  logic [7:0]     s_amount,
    input  tcp_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           q_push,
    output tcp_pkg::cmd_t  q_cmd
);
    import tcp_pkg::*;

    logic signed [10:0] row_abs;
    logic signed [10:0] row_off;
    logic [6:0]         row_max;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        // Offset the row by the top margin in origin mode.
        row_off = cfg.origin ? $signed({4'b0000, cfg.top}) : 11'sd0;
        row_abs = $signed({{2{s_target_row[8]}}, s_target_row}) + row_off;
        row_max = cfg.origin ? cfg.bot : cfg.lrow;

        q_cmd.op     = op_t'(s_operation);
        q_cmd.amount = s_amount;

        if (row_abs < 11'sd0) begin
            q_cmd.set_row = 7'd0;
        end else if (row_abs > $signed({4'b0000, row_max})) begin
            q_cmd.set_row = row_max;
        end else begin
            q_cmd.set_row = row_abs[6:0];
        end

        if (s_target_col[8]) begin
            q_cmd.set_col = 8'd0;
        end else if (s_target_col[7:0] > cfg.lcol) begin
            q_cmd.set_col = cfg.lcol;
        end else begin
            q_cmd.set_col = s_target_col[7:0];
        end
    end

endmodule

FILE: rtl/tcp_fifo.sv
// Short command queue between the front end and the back end.
// Push and pop in the same cycle are allowed. Depends on tcp_pkg.
module tcp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcp_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tcp_pkg::cmd_t  pop_cmd
);
    import tcp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/tcp_back.sv
// Back end of the cursor positioner: executes commands on the cursor position.
// Holds the position registers and the output register. Depends on tcp_pkg.
module tcp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  tcp_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  tcp_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [6:0]     m_cursor_row,
    output logic [7:0]     m_cursor_col,
    output logic [7:0]     m_scroll_lines,
    output logic           m_scroll_reverse
);
    import tcp_pkg::*;

    logic [6:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;
    logic       valid_reg;
    logic [6:0] out_row_reg;
    logic [7:0] out_col_reg;
    logic [7:0] lines_reg, lines_next;
    logic       rev_reg, rev_next;

    logic [8:0]        row_sum;
    logic signed [9:0] row_diff;
    logic [6:0]        down_lim, down_row;
    logic [6:0]        up_lim, up_row;
    logic [8:0]        col_sum;
    logic [8:0]        fwd_lines;
    logic [8:0]        rev_lines;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        row_sum  = {2'b00, row_reg} + {1'b0, q_cmd.amount};
        row_diff = $signed({3'b000, row_reg}) - $signed({2'b00, q_cmd.amount});
        col_sum  = {1'b0, col_reg} + {1'b0, q_cmd.amount};

        // Outside the region the screen edge bounds the move.
        down_lim = (row_reg > cfg.bot) ? cfg.lrow : cfg.bot;
        down_row = (row_sum > {2'b00, down_lim}) ? down_lim : row_sum[6:0];
        up_lim   = (row_reg < cfg.top) ? 7'd0 : cfg.top;
        up_row   = (row_diff < $signed({3'b000, up_lim})) ? up_lim : row_diff[6:0];

        fwd_lines = row_sum - {2'b00, cfg.bot};
        rev_lines = {1'b0, q_cmd.amount} + {2'b00, cfg.top} - {2'b00, row_reg};

        row_next   = row_reg;
        col_next   = col_reg;
        lines_next = 8'd0;
        rev_next   = 1'b0;

        unique case (q_cmd.op)
            OP_SET: begin
                row_next = q_cmd.set_row;
                col_next = q_cmd.set_col;
            end
            OP_LEFT: begin
                col_next = ({1'b0, col_reg} < {1'b0, q_cmd.amount}) ? 8'd0
                                                                    : col_reg - q_cmd.amount;
            end
            OP_RIGHT: begin
                col_next = (col_sum > {1'b0, cfg.lcol}) ? cfg.lcol : col_sum[7:0];
            end
            OP_DOWN: begin
                row_next = down_row;
            end
            OP_UP: begin
                row_next = up_row;
            end
            OP_INDEX: begin
                if (row_reg > cfg.bot || row_sum <= {2'b00, cfg.bot}) begin
                    row_next = down_row;
                end else begin
                    // Crossing the bottom margin: stop there and scroll the rest.
                    row_next   = cfg.bot;
                    lines_next = fwd_lines[7:0];
                end
            end
            OP_REV_IDX: begin
                if (row_reg < cfg.top || row_diff >= $signed({3'b000, cfg.top})) begin
                    row_next = up_row;
                end else begin
                    row_next   = cfg.top;
                    lines_next = rev_lines[7:0];
                    rev_next   = 1'b1;
                end
            end
            OP_CR: begin
                col_next = 8'd0;
            end
            default: begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= 7'd0;
            col_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_row_reg <= row_next;
            out_col_reg <= col_next;
            lines_reg   <= lines_next;
            rev_reg     <= rev_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_cursor_row     = out_row_reg;
    assign m_cursor_col     = out_col_reg;
    assign m_scroll_lines   = lines_reg;
    assign m_scroll_reverse = rev_reg;

endmodule

FILE: rtl/terminal_cursor_positioner_top.sv
// Top level of the terminal cursor positioner: configuration registers and
// the front end, command queue and back end. Depends on tcp_pkg, tcp_front,
// tcp_fifo and tcp_back.
//
// Usage:
//   Commands enter on the s_ channel (valid/ready); each accepted command
//   yields exactly one result on the m_ channel (valid/ready): the cursor
//   row and column after the command, plus a scroll count and direction
//   for index and reverse index that cross a margin.
//   Configuration registers (top margin, bottom margin, last row, last
//   column, origin mode) are written through cfg_we/cfg_index/cfg_wdata;
//   the user must write them only while no command is in flight, and the
//   block itself does not enforce this.
//   A command is written into the queue, popped by the back end, and its
//   result is registered in the output register that drives m_.
//   Throughput: one command per cycle while m_ready stays high, set by the
//   clamp and compare path on the position registers in the back end.
//   When the receiver stalls, the result holds in the output register and
//   the two-entry queue keeps taking commands until it fills; s_ready then
//   drops until results drain.
//   Reset (aresetn low, synchronous) empties the queue, drops any pending
//   result, homes the cursor to row 0 column 0 and restores the default
//   80 by 24 screen with full-screen margins.
module terminal_cursor_positioner_top (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write port
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    // Command channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [8:0] s_target_row,
    input  logic [8:0] s_target_col,
    input  logic [7:0] s_amount,
    // Result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_cursor_row,
    output logic [7:0] m_cursor_col,
    output logic [7:0] m_scroll_lines,
    output logic       m_scroll_reverse
);
    import tcp_pkg::*;

    logic [6:0] top_margin_reg;
    logic [6:0] bottom_margin_reg;
    logic [6:0] last_row_reg;
    logic [7:0] last_col_reg;
    logic       origin_mode_reg;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_margin_reg    <= 7'd0;
            bottom_margin_reg <= 7'd23;
            last_row_reg      <= 7'd23;
            last_col_reg      <= 8'd79;
            origin_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TOP_MARGIN:    top_margin_reg    <= cfg_wdata[6:0];
                CFG_BOTTOM_MARGIN: bottom_margin_reg <= cfg_wdata[6:0];
                CFG_LAST_ROW:      last_row_reg      <= cfg_wdata[6:0];
                CFG_LAST_COL:      last_col_reg      <= cfg_wdata;
                CFG_ORIGIN_MODE:   origin_mode_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Cap the bottom margin and screen edges to the screen size limits once, for both ends.
    always_comb begin
        cfg.top    = top_margin_reg;
        cfg.bot    = cap_row(bottom_margin_reg);
        cfg.lrow   = cap_row(last_row_reg);
        cfg.lcol   = cap_col(last_col_reg);
        cfg.origin = origin_mode_reg;
    end

    tcp_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_target_row (s_target_row),
        .s_target_col (s_target_col),
        .s_amount     (s_amount),
        .cfg          (cfg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    tcp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    tcp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_cmd            (pop_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_row     (m_cursor_row),
        .m_cursor_col     (m_cursor_col),
        .m_scroll_lines   (m_scroll_lines),
        .m_scroll_reverse (m_scroll_reverse)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for terminal_cursor_positioner_top: cursor moves,
// scroll reporting and margin handling checked against an in-bench predictor.
// Depends on tcp_pkg and the RTL top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcp_pkg::*;

    typedef struct packed {
        op_t        op;
        logic [8:0] trow;
        logic [8:0] tcol;
        logic [7:0] amount;
    } cursor_cmd_t;

    typedef struct packed {
        logic [6:0] row;
        logic [7:0] col;
        logic [7:0] lines;
        logic       rev;
    } cursor_result_t;

    // DUT ports; every input starts at a known value.
    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = CFG_TOP_MARGIN;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_operation = OP_SET;
    logic [8:0] s_target_row = 9'd0;
    logic [8:0] s_target_col = 9'd0;
    logic [7:0] s_amount = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_cursor_row;
    logic [7:0] m_cursor_col;
    logic [7:0] m_scroll_lines;
    logic       m_scroll_reverse;

    // Shadow of the configuration registers, mirrored on every write.
    logic [6:0] scr_top = 7'd0;
    logic [6:0] scr_bot = 7'd23;
    logic [6:0] scr_lrow = 7'd23;
    logic [7:0] scr_lcol = 8'd79;
    logic       scr_origin = 1'b0;

    // Predicted cursor position after the last accepted command.
    logic [6:0] cursor_row_q = 7'd0;
    logic [7:0] cursor_col_q = 8'd0;

    cursor_cmd_t    pending_cmds[$];
    cursor_result_t expected_cursor_q[$];

    // Idle knobs, in percent; the stimulus process changes them per phase.
    int src_gap_pct = 0;
    int sink_stall_pct = 0;

    int n_cmds = 0;
    int n_results = 0;
    int n_scrolls = 0;
    int n_rev_scrolls = 0;
    int n_cfg_writes = 0;
    int n_fail = 0;

    terminal_cursor_positioner_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_target_row     (s_target_row),
        .s_target_col     (s_target_col),
        .s_amount         (s_amount),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_row     (m_cursor_row),
        .m_cursor_col     (m_cursor_col),
        .m_scroll_lines   (m_scroll_lines),
        .m_scroll_reverse (m_scroll_reverse)
    );

    always #5 aclk = ~aclk;

    // Downward move: a cursor below the bottom margin is bounded by the
    // last screen row, otherwise by the bottom margin.
    function automatic int clamp_down(int row, int n, int bot, int lrow);
        int lim;
        lim = (row > bot) ? lrow : bot;
        row = row + n;
        return (row > lim) ? lim : row;
    endfunction

    // Upward move: a cursor above the top margin is bounded by row 0.
    function automatic int clamp_up(int row, int n, int top);
        int lim;
        lim = (row < top) ? 0 : top;
        row = row - n;
        return (row < lim) ? lim : row;
    endfunction

    // Work out the cursor and scroll request that one command produces.
    function automatic cursor_result_t apply_cursor_cmd(input cursor_cmd_t c,
                                                        input logic [6:0] row_in,
                                                        input logic [7:0] col_in);
        cursor_result_t r;
        int row, col, trow, tcol, n, top, bot, lrow, lcol, maxr, lines;
        logic rev;
        row   = row_in;
        col   = col_in;
        trow  = $signed(c.trow);
        tcol  = $signed(c.tcol);
        n     = c.amount;
        top   = scr_top;
        bot   = scr_bot;
        lrow  = scr_lrow;
        lcol  = scr_lcol;
        lines = 0;
        rev   = 1'b0;
        case (c.op)
            OP_SET: begin
                maxr = lrow;
                if (scr_origin) begin
                    trow = trow + top;
                    maxr = bot;
                end
                if (trow < 0) trow = 0;
                if (tcol < 0) tcol = 0;
                col = (tcol <= lcol) ? tcol : lcol;
                row = (trow <= maxr) ? trow : maxr;
            end
            OP_LEFT: begin
                col = col - n;
                if (col < 0) col = 0;
            end
            OP_RIGHT: begin
                col = col + n;
                if (col > lcol) col = lcol;
            end
            OP_DOWN: row = clamp_down(row, n, bot, lrow);
            OP_UP:   row = clamp_up(row, n, top);
            OP_INDEX: begin
                if (row > bot || row + n <= bot) begin
                    row = clamp_down(row, n, bot, lrow);
                end else begin
                    lines = n - (bot - row);
                    row   = bot;
                end
            end
            OP_REV_IDX: begin
                if (row < top || row - n >= top) begin
                    row = clamp_up(row, n, top);
                end else begin
                    lines = n - (row - top);
                    row   = top;
                    rev   = 1'b1;
                end
            end
            default: col = 0;
        endcase
        r.row   = 7'(row);
        r.col   = 8'(col);
        r.lines = 8'(lines);
        r.rev   = (lines != 0) ? rev : 1'b0;
        return r;
    endfunction

    // Idle stretch length: none unless the percent chance hits; then mostly short, now and then long.
    function automatic int idle_length(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Command driver: hold the payload until transfer, then apply an
    // optional gap before the next pending command goes out. The predictor
    // runs at the edge of each transfer so its state follows the DUT's.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin : drive_cmds
        cursor_cmd_t    sent;
        cursor_result_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                sent.op     = op_t'(s_operation);
                sent.trow   = s_target_row;
                sent.tcol   = s_target_col;
                sent.amount = s_amount;
                nxt = apply_cursor_cmd(sent, cursor_row_q, cursor_col_q);
                cursor_row_q = nxt.row;
                cursor_col_q = nxt.col;
                expected_cursor_q.push_back(nxt);
                n_cmds++;
                if (nxt.lines != 0) begin
                    n_scrolls++;
                    if (nxt.rev) n_rev_scrolls++;
                end
            end
            if (s_valid && !s_ready) begin
                // hold: payload and valid stay as they are
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                sent = pending_cmds.pop_front();
                s_operation  <= sent.op;
                s_target_row <= sent.trow;
                s_target_col <= sent.tcol;
                s_amount     <= sent.amount;
                s_valid      <= 1'b1;
                gap_left     <= idle_length(src_gap_pct);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every transfer on m_ against the oldest
    // expectation, and throttle m_ready with random stalls.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin : check_results
        cursor_result_t want;
        int             stall;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_cursor_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("[%0t] unexpected result: row %0d col %0d lines %0d rev %0d",
                                 $realtime, m_cursor_row, m_cursor_col, m_scroll_lines,
                                 m_scroll_reverse);
                end else begin
                    want = expected_cursor_q.pop_front();
                    if (m_cursor_row !== want.row || m_cursor_col !== want.col ||
                        m_scroll_lines !== want.lines || m_scroll_reverse !== want.rev) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display({"[%0t] result %0d: expected row %0d col %0d lines %0d ",
                                      "rev %0d, got row %0d col %0d lines %0d rev %0d"},
                                     $realtime, n_results, want.row, want.col, want.lines,
                                     want.rev, m_cursor_row, m_cursor_col, m_scroll_lines,
                                     m_scroll_reverse);
                    end
                end
            end
            // Stall the receiver now and then; ready is free to drop anytime.
            stall = idle_length(sink_stall_pct);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (stall != 0) begin
                stall_left <= stall - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TOP_MARGIN:    scr_top    = val[6:0];
            CFG_BOTTOM_MARGIN: scr_bot    = val[6:0];
            CFG_LAST_ROW:      scr_lrow   = val[6:0];
            CFG_LAST_COL:      scr_lcol   = val;
            CFG_ORIGIN_MODE:   scr_origin = val[0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic set_screen(input int top, input int bot, input int lrow,
                              input int lcol, input int origin);
        cfg_write(CFG_TOP_MARGIN, 8'(top));
        cfg_write(CFG_BOTTOM_MARGIN, 8'(bot));
        cfg_write(CFG_LAST_ROW, 8'(lrow));
        cfg_write(CFG_LAST_COL, 8'(lcol));
        cfg_write(CFG_ORIGIN_MODE, 8'(origin));
    endtask

    task automatic queue_cmd(input op_t op, input int trow, input int tcol, input int amount);
        cursor_cmd_t c;
        c.op     = op;
        c.trow   = 9'(trow);
        c.tcol   = 9'(tcol);
        c.amount = 8'(amount);
        pending_cmds.push_back(c);
    endtask

    // Drain: nothing pending, nothing in flight, then let the pipe settle.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_valid || expected_cursor_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        cursor_cmd_t c;
        int          top, bot, lrow, lcol, origin, guard;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default 80x24 screen: edges, clamps, scroll at both margins,
        // zero counts, and fields that the operation ignores.
        src_gap_pct    = 20;
        sink_stall_pct = 10;
        queue_cmd(OP_SET,     255,  255,   0);
        queue_cmd(OP_SET,    -256, -256, 255);
        queue_cmd(OP_LEFT,    -1,   -1,  255);
        queue_cmd(OP_RIGHT,    0,    0,  255);
        queue_cmd(OP_RIGHT,  255,  255,    0);
        queue_cmd(OP_DOWN,     0,    0,  255);
        queue_cmd(OP_INDEX,    0,    0,    5);
        queue_cmd(OP_INDEX,    0,    0,    0);
        queue_cmd(OP_UP,       0,    0,  255);
        queue_cmd(OP_REV_IDX,  0,    0,    3);
        queue_cmd(OP_REV_IDX,  0,    0,    0);
        queue_cmd(OP_CR,     255,  255,  255);
        wait_idle();

        // Origin mode with a narrow region on a full-size screen.
        set_screen(5, 10, 127, 255, 1);
        queue_cmd(OP_SET,    -256,   3,    0);
        queue_cmd(OP_UP,        0,   0,    7);
        queue_cmd(OP_SET,     255, 255,    0);
        queue_cmd(OP_SET,       3,   0,    0);
        queue_cmd(OP_INDEX,     0,   0,  255);
        queue_cmd(OP_REV_IDX,   0,   0,  255);
        wait_idle();

        // Park the cursor far out, then shrink the screen under it and
        // swap the margins out of order.
        cfg_write(CFG_ORIGIN_MODE, 8'd0);
        queue_cmd(OP_SET, 120, 250, 0);
        wait_idle();
        set_screen(127, 0, 10, 20, 0);
        queue_cmd(OP_LEFT,    0, 0, 0);
        queue_cmd(OP_UP,      0, 0, 0);
        queue_cmd(OP_RIGHT,   0, 0, 0);
        queue_cmd(OP_DOWN,    0, 0, 0);
        queue_cmd(OP_INDEX,   0, 0, 2);
        queue_cmd(OP_REV_IDX, 0, 0, 4);
        wait_idle();

        // Random phases, each under its own screen setup and idle mix.
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin top = 0;   bot = 127; lrow = 127; lcol = 255; origin = 1; end
                1: begin top = 127; bot = 0;   lrow = 127; lcol = 255; origin = 0; end
                2: begin top = 0;   bot = 0;   lrow = 0;   lcol = 0;   origin = 1; end
                default: begin
                    lrow = $urandom_range(1, 127);
                    lcol = $urandom_range(0, 255);
                    origin = $urandom_range(0, 1);
                    if ($urandom_range(0, 9) < 7) begin
                        bot = $urandom_range(0, lrow);
                        top = $urandom_range(0, bot);
                    end else begin
                        bot = $urandom_range(0, 127);
                        top = $urandom_range(0, 127);
                    end
                end
            endcase
            set_screen(top, bot, lrow, lcol, origin);

            // Every third phase runs with no idling at all.
            case (phase % 3)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 30; sink_stall_pct = 15; end
                default: begin src_gap_pct = 60; sink_stall_pct = 35; end
            endcase

            for (int k = 0; k < 135; k++) begin
                c.op = op_t'($urandom_range(0, 7));
                // Rows: full range, on screen, or near a margin.
                case ($urandom_range(0, 3))
                    0: c.trow = 9'($urandom);
                    1: c.trow = 9'($urandom_range(0, 127));
                    2: c.trow = 9'(int'(scr_bot) - int'($urandom_range(0, 4)));
                    default: c.trow = 9'(int'(scr_top) + int'($urandom_range(0, 4)));
                endcase
                c.tcol = $urandom_range(0, 1) ? 9'($urandom) : 9'($urandom_range(0, scr_lcol));
                // Counts: mostly small so the cursor wanders near the margins.
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c.amount = 8'($urandom_range(0, 4));
                    4, 5:       c.amount = 8'($urandom_range(0, 30));
                    6:          c.amount = $urandom_range(0, 1) ? 8'd0 : 8'd255;
                    default:    c.amount = 8'($urandom);
                endcase
                pending_cmds.push_back(c);
                // Keep the queue short so idling reaches every phase.
                while (pending_cmds.size() > 4) @(posedge aclk);
            end
            wait_idle();
        end

        // Final drain with a bound; anything still expected is a failure.
        guard = 0;
        while (expected_cursor_q.size() != 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (expected_cursor_q.size() != 0) begin
            n_fail += expected_cursor_q.size();
            $display("%0d results never arrived", expected_cursor_q.size());
        end

        $display("Covered %0d commands and %0d results, %0d scroll requests (%0d reverse).",
                 n_cmds, n_results, n_scrolls, n_rev_scrolls);
        $display("Applied %0d register writes across 13 screen setups; %0d failures.",
                 n_cfg_writes, n_fail);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("Timed out waiting for the run to finish");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tcp_pkg.sv
rtl/tcp_front.sv
rtl/tcp_fifo.sv
rtl/tcp_back.sv
rtl/terminal_cursor_positioner_top.sv
test/tb_top.sv
